// File: sv/bitmap_page_frame_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Immediate-consequence and next-cycle property forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpfa assertion failed");

// next-cycle implication
`define BPFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpfa assertion failed");

`endif

// File: sv/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types and constants shared by the page frame allocator modules.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int BLOCK_SHIFT = 12;
    localparam int CNT_W       = 16;
    localparam int BLK_W       = 17;
    localparam logic [CNT_W-1:0] COUNTER_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 16'd32768;

    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE     = 3'd1,
        OP_TEST     = 3'd2,
        OP_RESERVE  = 3'd3,
        OP_RELEASE  = 3'd4,
        OP_MARK_ALL = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_RD,
        S_MOD,
        S_UPD,
        S_ARD,
        S_ACHK,
        S_MARK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic div;
        logic test;
        logic modify;
        logic update;
        logic alloc_take;
        logic advance;
        logic fill;
        logic mark_count;
        logic set_oor;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_of_range;
        logic range_last;
        logic alloc_word_ok;
        logic word_has_zero;
        logic fill_last;
        logic is_test;
    } t_sts;

endpackage

// File: sv/bitmap_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// One-bit-per-4KiB-block usage map with allocate, free, test, range and
// mark-all operations, plus a saturating used-block counter.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result is
// shown for a single cycle with o_done high and cannot be held off. After
// reset the block runs a clearing pass that fills the map with ones, one map
// word per cycle, with busy high. The map is a memory with one write port
// and one registered read port, both addressed by the same map word index.
// Allocate reads map words in turn until one has a free block or the managed
// range ends; free, reserve and release read and rewrite each map word that
// the range touches; test reads a single map word; mark-all rewrites every
// map word; an unmanaged address and an unused code end without touching
// the map. block_count may only be written while busy is low and no result
// is pending.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top #(
    parameter int MAX_BLOCKS    = 32768,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [bpfa_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic [2:0]                 i_operation,
    input  logic [31:0]                i_phys_address,
    input  logic [31:0]                i_range_length,
    output logic                       o_done,
    output logic [31:0]                o_granted_address,
    output logic                       o_is_allocated,
    output logic [1:0]                 o_status,
    output logic [bpfa_pkg::CNT_W-1:0] o_used_blocks
);

    import bpfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    bpfa_dpath #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_operation       (i_operation),
        .i_phys_address    (i_phys_address),
        .i_range_length    (i_range_length),
        .o_done            (o_done),
        .o_granted_address (o_granted_address),
        .o_is_allocated    (o_is_allocated),
        .o_status          (o_status),
        .o_used_blocks     (o_used_blocks)
    );

endmodule

// File: sv/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer for the allocator: clearing pass, word scans and range updates.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [2:0]     i_operation,
    input  bpfa_pkg::t_sts i_sts,
    output bpfa_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    import bpfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_operation) inside
                        OP_ALLOC:    n_state = S_ARD;
                        OP_MARK_ALL: n_state = S_MARK;
                        OP_FREE, OP_TEST, OP_RESERVE, OP_RELEASE: n_state = S_CHECK;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_sts.out_of_range) begin
                    o_cmd.set_oor = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (i_sts.is_test) begin
                    o_cmd.test = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.modify = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.range_last ? S_DONE : S_RD;
            end
            S_ARD: begin
                n_state = i_sts.alloc_word_ok ? S_ACHK : S_DONE;
            end
            S_ACHK: begin
                if (i_sts.word_has_zero) begin
                    o_cmd.alloc_take = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_ARD;
                end
            end
            S_MARK: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.mark_count = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: sv/bpfa_dpath.sv
// ----------------------------------------------------------------------------
// bpfa_dpath
// Usage map memory, used-block counter, word/bit arithmetic and result regs.
// ----------------------------------------------------------------------------
module bpfa_dpath #(
    parameter int MAX_BLOCKS    = 32768,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpfa_pkg::t_cmd             i_cmd,
    output bpfa_pkg::t_sts             o_sts,
    input  logic                       i_cfg_we,
    input  logic [bpfa_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic [2:0]                 i_operation,
    input  logic [31:0]                i_phys_address,
    input  logic [31:0]                i_range_length,
    output logic                       o_done,
    output logic [31:0]                o_granted_address,
    output logic                       o_is_allocated,
    output logic [1:0]                 o_status,
    output logic [bpfa_pkg::CNT_W-1:0] o_used_blocks
);

    import bpfa_pkg::*;

    localparam int WB        = MAP_WORD_BITS;
    localparam int MAP_WORDS = (MAX_BLOCKS + WB - 1) / WB;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW        = $clog2(WB + 1);
    // ceil(2^32 / WB): exact quotient for any 16-bit block number
    localparam logic [31:0] RECIP = 32'(((64'd1 << 32) + 64'(WB) - 64'd1) / 64'(WB));
    localparam logic [CNT_W-1:0] CNT_RESET =
        CNT_W'((MAX_BLOCKS < 65535) ? MAX_BLOCKS : 65535);
    localparam logic [BLK_W-1:0] WB_B      = BLK_W'(WB);
    localparam logic [WAW:0]     LAST_WORD = (WAW + 1)'(MAP_WORDS - 1);

    logic [CNT_W-1:0] r_block_count;
    logic [CNT_W-1:0] r_counter;
    t_op              r_op;
    logic [19:0]      r_blk;
    logic [20:0]      r_count;
    logic [CNT_W-1:0] r_end;
    logic [47:0]      r_prod;
    logic [WAW:0]     r_word;
    logic [BLK_W-1:0] r_base;
    logic [IW-1:0]    r_pop;
    logic [31:0]      r_granted;
    logic             r_tested;
    t_status          r_status;

    logic             r_done;
    logic [31:0]      r_out_granted;
    logic             r_out_tested;
    logic [1:0]       r_out_status;
    logic [CNT_W-1:0] r_out_used;

    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] cnt_clip;
    logic [CNT_W-1:0] quo;
    logic [BLK_W-1:0] start17;
    logic [BLK_W-1:0] end17;
    logic [BLK_W-1:0] end_diff;
    logic [IW-1:0]    lo;
    logic [IW-1:0]    hi;
    logic [WB-1:0]    mask;
    logic [WB-1:0]    rd;
    logic [WB-1:0]    changed;
    logic [WB-1:0]    new_word;
    logic [WB-1:0]    zero_hot;
    logic [WB-1:0]    wdata;
    logic [IW-1:0]    pop;
    logic [IW-1:0]    zero_idx;
    logic [BLK_W-1:0] alloc_blk;
    logic             set_bits;
    logic             we;
    logic [CNT_W:0]   cnt_sum;

    bpfa_ram #(
        .WIDTH (WB),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_word[WAW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_word[WAW-1:0]),
        .o_rdata (rd)
    );

    assign lim = (32'(r_block_count) < 32'(MAX_BLOCKS)) ? r_block_count
                                                       : CNT_W'(MAX_BLOCKS);
    assign avail    = lim - r_blk[CNT_W-1:0];
    assign cnt_clip = (r_count < 21'(avail)) ? r_count[CNT_W-1:0] : avail;
    assign quo      = r_prod[47:32];

    assign start17  = {1'b0, r_blk[CNT_W-1:0]};
    assign end17    = {1'b0, r_end};
    assign end_diff = end17 - r_base;
    assign lo = (start17 > r_base) ? IW'(start17 - r_base) : '0;
    assign hi = (end17 <= r_base) ? '0 : ((end_diff >= WB_B) ? IW'(WB) : IW'(end_diff));

    assign set_bits = (r_op == OP_RESERVE);
    assign changed  = set_bits ? (mask & ~rd) : (mask & rd);
    assign new_word = set_bits ? (rd | mask) : (rd & ~mask);
    assign zero_hot = ~rd & (rd + WB'(1));
    assign alloc_blk = r_base + BLK_W'(zero_idx);

    always_comb begin
        mask     = '0;
        pop      = '0;
        zero_idx = '0;
        for (int j = 0; j < WB; j++) begin
            mask[j]  = (IW'(j) >= lo) && (IW'(j) < hi);
            pop      = pop + IW'(changed[j]);
            zero_idx = zero_idx | ({IW{zero_hot[j]}} & IW'(j));
        end
    end

    assign we    = i_cmd.fill | i_cmd.modify | i_cmd.alloc_take;
    assign wdata = i_cmd.fill ? '1 : (i_cmd.modify ? new_word : (rd | zero_hot));

    assign o_sts.out_of_range  = (r_blk >= {4'b0, lim});
    assign o_sts.range_last    = ((r_base + WB_B) >= end17);
    assign o_sts.alloc_word_ok = ((r_base + WB_B) <= {1'b0, lim});
    assign o_sts.word_has_zero = ~(&rd);
    assign o_sts.fill_last     = (r_word == LAST_WORD);
    assign o_sts.is_test       = (r_op == OP_TEST);

    assign cnt_sum = {1'b0, r_counter} + (CNT_W + 1)'(r_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= CNT_RESET;
        end else if (i_cmd.mark_count) begin
            r_counter <= lim;
        end else if (i_cmd.alloc_take) begin
            if (r_counter != COUNTER_MAX) begin
                r_counter <= r_counter + CNT_W'(1);
            end
        end else if (i_cmd.update) begin
            if (set_bits) begin
                r_counter <= cnt_sum[CNT_W] ? COUNTER_MAX : cnt_sum[CNT_W-1:0];
            end else begin
                r_counter <= (CNT_W'(r_pop) > r_counter) ? '0 : r_counter - CNT_W'(r_pop);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_base <= '0;
        end else if (i_cmd.load) begin
            r_word <= '0;
            r_base <= '0;
        end else if (i_cmd.fill) begin
            r_word <= r_word + (WAW + 1)'(1);
        end else if (i_cmd.div) begin
            r_word <= (WAW + 1)'(quo);
            r_base <= BLK_W'({1'b0, quo} * WB_B);
        end else if (i_cmd.advance || i_cmd.update) begin
            r_word <= r_word + (WAW + 1)'(1);
            r_base <= r_base + WB_B;
        end
    end

    // operation payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_blk <= i_phys_address[31:BLOCK_SHIFT];
            case (i_operation)
                OP_RESERVE: r_count <= {1'b0, i_range_length[31:BLOCK_SHIFT]} + 21'd1;
                OP_RELEASE: r_count <= {1'b0, i_range_length[31:BLOCK_SHIFT]};
                default:    r_count <= 21'd1;
            endcase
        end
        if (i_cmd.prep) begin
            r_end  <= r_blk[CNT_W-1:0] + cnt_clip;
            r_prod <= 48'(r_blk[CNT_W-1:0]) * 48'(RECIP);
        end
        if (i_cmd.modify) begin
            r_pop <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_granted <= '0;
            r_tested  <= 1'b0;
            r_status  <= (i_operation == OP_ALLOC) ? ST_NO_FREE : ST_OK;
        end else if (i_cmd.set_oor) begin
            r_status <= ST_OUT_OF_RANGE;
        end else if (i_cmd.alloc_take) begin
            r_status  <= ST_OK;
            r_granted <= 32'(alloc_blk) << BLOCK_SHIFT;
        end else if (i_cmd.test) begin
            r_tested <= |(rd & mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_granted <= r_granted;
            r_out_tested  <= r_tested;
            r_out_status  <= r_status;
            r_out_used    <= r_counter;
        end
    end

    assign o_done            = r_done;
    assign o_granted_address = r_out_granted;
    assign o_is_allocated    = r_out_tested;
    assign o_status          = r_out_status;
    assign o_used_blocks     = r_out_used;

endmodule

// File: sv/bpfa_checker.sv
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level checks on command acceptance and result consistency.
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_top_assert.svh"

module bpfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_granted_address,
    input logic        o_is_allocated,
    input logic [1:0]  o_status
);

    import bpfa_pkg::*;

    // an accepted command makes the sequencer busy in the cycle after it is taken
    `BPFA_ASSERT_NXT(a_start_goes_busy, start && !busy, busy)
    // results appear only once the work has finished
    `BPFA_ASSERT_IMP(a_done_when_idle, o_done, !busy && $past(busy))
    `BPFA_ASSERT_IMP(a_no_free_clean, o_done && (o_status == ST_NO_FREE), (o_granted_address == 32'd0) && !o_is_allocated)
    `BPFA_ASSERT_IMP(a_grant_aligned, o_done, o_granted_address[11:0] == 12'd0)

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (.*);
